>>> design/hsi_pkg.sv
package hsi_pkg;

  // configuration register map
  typedef enum logic [2:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_SAT_LOW  = 3'd2,
    REG_SAT_HIGH = 3'd3,
    REG_INT_LOW  = 3'd4,
    REG_INT_HIGH = 3'd5
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;

  // hue numerator and divisor are both scaled by 250 so that the 0.0001 turn
  // offset of the blue-minimum formula becomes an integer term
  localparam int unsigned HueScale = 30000;  // 120 degrees * 250
  localparam int unsigned HueOffs  = 9;      // 0.0001 turn * 360 * 250
  localparam int unsigned TurnDiv  = 250;
  localparam int unsigned SatScale = 255;

  // ceil(2^11 / 3), exact divide by three for sums below 2048
  localparam int unsigned IntRecip = 683;

  // stages outside the dividers: front end, numerator build, result register
  localparam int unsigned PreStages  = 2;
  localparam int unsigned PostStages = 1;

endpackage

>>> design/hsi_div.sv
module hsi_div #(
  parameter int unsigned NW = 30,
  parameter int unsigned DW = 17,
  parameter int unsigned QW = 13,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic          exact_o,
  output logic [SW-1:0] side_o
);

  // one quotient bit per stage, restoring
  logic          val  [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [QW-1:0] quo  [0:QW];
  logic [QW-1:0] low  [0:QW];
  logic [DW-1:0] den  [0:QW];
  logic [SW-1:0] side [0:QW];

  assign val[0]  = valid_i;
  assign rem[0]  = DW'(num_i[NW-1:QW]);
  assign quo[0]  = '0;
  assign low[0]  = num_i[QW-1:0];
  assign den[0]  = den_i;
  assign side[0] = side_i;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;
    logic [QW-1:0] quo_d;

    always_comb begin
      trial = {rem[s], low[s][QW-1-s]};
      ge    = trial >= {1'b0, den[s]};
      diff  = trial - {1'b0, den[s]};
      quo_d = quo[s];
      quo_d[QW-1-s] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val[s+1] <= 1'b0;
      end else begin
        val[s+1] <= val[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem[s+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo[s+1]  <= quo_d;
      low[s+1]  <= low[s];
      den[s+1]  <= den[s];
      side[s+1] <= side[s];
    end
  end

  assign valid_o = val[QW];
  assign quo_o   = quo[QW];
  assign exact_o = (rem[QW] == '0);
  assign side_o  = side[QW];

endmodule

>>> design/rgb_to_hsi_color_threshold.sv
// channel   direction  handshake                 payload
// pixel     in         start_i, busy_o           chan_first_i, chan_second_i, chan_third_i
// result    out        done_o (one-cycle strobe)  in_window_o, hue/sat/int_sixteenths_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
// one pixel word per clock, every clock; busy_o stays low
// from start to done a word passes through these registered stages:
//   front end, numerator build, one stage per quotient bit of the dividers, result register
// hue and saturation divisions run as parallel restoring pipelines of FRAC_BITS + 9 stages
// intensity uses a reciprocal multiply and rides along in the saturation pipeline
// reset clears the valid bits and loads the default windows
// the receiver cannot stall; results are never held back
module rgb_to_hsi_color_threshold #(
  parameter int unsigned FRAC_BITS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [7:0]                   chan_first_i,
  input  logic [7:0]                   chan_second_i,
  input  logic [7:0]                   chan_third_i,
  output logic                         done_o,
  output logic                         in_window_o,
  output logic [12:0]                  hue_sixteenths_o,
  output logic [11:0]                  sat_sixteenths_o,
  output logic [11:0]                  int_sixteenths_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hsi_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hsi_pkg::CfgDataW-1:0] cfg_data_i
);
  import hsi_pkg::*;

  // quotient width covers hue up to 360 degrees; sat and int fit as well
  localparam int unsigned QW  = FRAC_BITS + 9;
  localparam int unsigned HNW = FRAC_BITS + 26;
  localparam int unsigned HDW = 17;
  localparam int unsigned SNW = FRAC_BITS + 18;
  localparam int unsigned SDW = 10;
  localparam int unsigned HOW = (QW > 13) ? QW : 13;
  localparam int unsigned SOW = (QW > 12) ? QW : 12;
  // fraction part of a remainder of one or two thirds
  localparam int unsigned IntOneThird  = (1 << FRAC_BITS) / 3;
  localparam int unsigned IntTwoThirds = (2 << FRAC_BITS) / 3;

  // config registers
  logic [8:0] hue_low_q, hue_high_q;
  logic [7:0] sat_low_q, sat_high_q, int_low_q, int_high_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= 9'd0;
      hue_high_q <= 9'd360;
      sat_low_q  <= 8'd0;
      sat_high_q <= 8'd255;
      int_low_q  <= 8'd0;
      int_high_q <= 8'd255;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_HUE_LOW:  hue_low_q  <= cfg_data_i;
        REG_HUE_HIGH: hue_high_q <= cfg_data_i;
        REG_SAT_LOW:  sat_low_q  <= cfg_data_i[7:0];
        REG_SAT_HIGH: sat_high_q <= cfg_data_i[7:0];
        REG_INT_LOW:  int_low_q  <= cfg_data_i[7:0];
        REG_INT_HIGH: int_high_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // front end: sum, minimum channel, hue denominator and ratio term
  logic        accept;
  logic [9:0]  sum_d;
  logic [7:0]  mn;
  logic [8:0]  den_d;
  logic [10:0] x_d;
  logic        blue_d;
  logic [9:0]  smn_d;
  logic        gray_d;

  assign accept = start_i && !busy_o;

  always_comb begin
    sum_d  = 10'(chan_first_i) + 10'(chan_second_i) + 10'(chan_third_i);
    blue_d = 1'b0;
    if (chan_first_i <= chan_second_i && chan_first_i <= chan_third_i) begin
      // red is the minimum
      mn    = chan_first_i;
      den_d = 9'(chan_second_i) + 9'(chan_third_i) - {chan_first_i, 1'b0};
      x_d   = 11'(den_d) + 11'(chan_third_i - chan_first_i);
    end else if (chan_second_i <= chan_third_i) begin
      // green is the minimum
      mn    = chan_second_i;
      den_d = 9'(chan_first_i) + 9'(chan_third_i) - {chan_second_i, 1'b0};
      x_d   = 11'(chan_first_i - chan_second_i) + {1'b0, den_d, 1'b0};
    end else begin
      // blue is the minimum
      mn     = chan_third_i;
      den_d  = 9'(chan_first_i) + 9'(chan_second_i) - {chan_third_i, 1'b0};
      x_d    = 11'(chan_second_i - chan_third_i);
      blue_d = 1'b1;
    end
    smn_d  = sum_d - (10'(mn) + {1'b0, mn, 1'b0});
    gray_d = (chan_first_i == chan_second_i) || (chan_second_i == chan_third_i);
  end

  logic        v1_q;
  logic [9:0]  sum1_q, smn1_q;
  logic [8:0]  den1_q;
  logic [10:0] x1_q;
  logic        blue1_q, gray1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    sum1_q  <= sum_d;
    smn1_q  <= smn_d;
    den1_q  <= den_d;
    x1_q    <= x_d;
    blue1_q <= blue_d;
    gray1_q <= gray_d;
  end

  // numerator build: constant products, one stage
  logic            v2_q;
  logic [HNW-1:0]  hnum2_q;
  logic [HDW-1:0]  hden2_q;
  logic [SNW-1:0]  snum2_q;
  logic [SDW-1:0]  sden2_q;
  logic [QW-1:0]   iq2_q;
  logic            ix2_q;
  logic            hzero2_q, szero2_q, gray2_q;
  logic [25:0]     hbase;
  logic [20:0]     iprod;
  logic [9:0]      iq0, i3;
  logic [1:0]      irem;
  logic [QW-1:0]   iq_d;
  logic            ix_d;

  assign hbase = 26'(HueScale) * 26'(x1_q)
               + (blue1_q ? 26'(HueOffs) * 26'(den1_q) : 26'd0);

  // intensity: sum / 3 by reciprocal, remainder picks the fraction bits
  always_comb begin
    iprod = 21'(sum1_q) * 21'(IntRecip);
    iq0   = iprod[20:11];
    i3    = iq0 + {iq0[8:0], 1'b0};
    irem  = sum1_q[1:0] - i3[1:0];
    iq_d  = QW'({iq0[7:0], {FRAC_BITS{1'b0}}});
    ix_d  = (irem == 2'd0);
    case (irem)
      2'd1:    iq_d = iq_d + QW'(IntOneThird);
      2'd2:    iq_d = iq_d + QW'(IntTwoThirds);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hnum2_q  <= {hbase, {FRAC_BITS{1'b0}}};
    hden2_q  <= HDW'(TurnDiv) * HDW'(den1_q);
    snum2_q  <= {18'(SatScale) * 18'(smn1_q), {FRAC_BITS{1'b0}}};
    sden2_q  <= sum1_q;
    iq2_q    <= iq_d;
    ix2_q    <= ix_d;
    hzero2_q <= (den1_q == '0);
    szero2_q <= (sum1_q == '0);
    gray2_q  <= gray1_q;
  end

  // two division pipelines in lockstep
  logic          hv, hx, sx, ix, hzero3, szero3, gray3;
  logic [QW-1:0] hq, sq, iq;
  logic [QW+2:0] sside3;

  hsi_div #(.NW(HNW), .DW(HDW), .QW(QW), .SW(1)) u_hue_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .num_i   (hnum2_q),
    .den_i   (hden2_q),
    .side_i  (hzero2_q),
    .valid_o (hv),
    .quo_o   (hq),
    .exact_o (hx),
    .side_o  (hzero3)
  );

  hsi_div #(.NW(SNW), .DW(SDW), .QW(QW), .SW(QW + 3)) u_sat_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .num_i   (snum2_q),
    .den_i   (sden2_q),
    .side_i  ({szero2_q, gray2_q, ix2_q, iq2_q}),
    .valid_o (),
    .quo_o   (sq),
    .exact_o (sx),
    .side_o  (sside3)
  );

  assign {szero3, gray3, ix, iq} = sside3;

  // window tests on exact values: truncated quotient plus exact flag
  logic [QW-1:0]  hq_f, sq_f, th;
  logic           hx_f, sx_f, tx;
  logic [QW-1:0]  h_lo, h_hi, s_lo, s_hi, i_lo, i_hi;
  logic           h_ge, h_le, hue_ok, pass_d;
  logic [HOW-1:0] hq_ext;
  logic [SOW-1:0] sq_ext, iq_ext;

  always_comb begin
    hq_f = hzero3 ? '0 : hq;
    hx_f = hzero3 ? 1'b1 : hx;
    sq_f = szero3 ? '0 : sq;
    sx_f = szero3 ? 1'b1 : sx;
    // pixels with the first two or the last two channels equal count as hue zero for the window only
    th   = gray3 ? '0 : hq_f;
    tx   = gray3 ? 1'b1 : hx_f;

    h_lo = {hue_low_q, {FRAC_BITS{1'b0}}};
    h_hi = {hue_high_q, {FRAC_BITS{1'b0}}};
    s_lo = QW'({sat_low_q, {FRAC_BITS{1'b0}}});
    s_hi = QW'({sat_high_q, {FRAC_BITS{1'b0}}});
    i_lo = QW'({int_low_q, {FRAC_BITS{1'b0}}});
    i_hi = QW'({int_high_q, {FRAC_BITS{1'b0}}});

    h_ge   = th >= h_lo;
    h_le   = (th < h_hi) || (th == h_hi && tx);
    // low above high wraps through zero
    hue_ok = (hue_low_q <= hue_high_q) ? (h_ge && h_le) : (h_ge || h_le);

    pass_d = hue_ok
          && (sq_f >= s_lo) && ((sq_f < s_hi) || (sq_f == s_hi && sx_f))
          && (iq >= i_lo) && ((iq < i_hi) || (iq == i_hi && ix));

    hq_ext = HOW'(hq_f);
    sq_ext = SOW'(sq_f);
    iq_ext = SOW'(iq);
  end

  logic        done_q, win_q;
  logic [12:0] hue_q;
  logic [11:0] sat_q, int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= hv;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= pass_d;
    hue_q <= hq_ext[12:0];
    sat_q <= sq_ext[11:0];
    int_q <= iq_ext[11:0];
  end

  assign done_o           = done_q;
  assign in_window_o      = win_q;
  assign hue_sixteenths_o = hue_q;
  assign sat_sixteenths_o = sat_q;
  assign int_sixteenths_o = int_q;

endmodule

>>> design/hsi_chk.sv
module hsi_chk #(
  parameter int unsigned FRAC_BITS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_o,
  input  logic [7:0]                   chan_first_i,
  input  logic [7:0]                   chan_second_i,
  input  logic [7:0]                   chan_third_i,
  input  logic                         done_o,
  input  logic                         in_window_o,
  input  logic [12:0]                  hue_sixteenths_o,
  input  logic [11:0]                  sat_sixteenths_o,
  input  logic [11:0]                  int_sixteenths_o,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [hsi_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hsi_pkg::CfgDataW-1:0] cfg_data_i
);
  import hsi_pkg::*;

  localparam int unsigned Lat = PreStages + FRAC_BITS + 9 + PostStages;

  // cycles since reset, saturating at the latency
  logic [$clog2(Lat+1)-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cnt_q != ($clog2(Lat+1))'(Lat)) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // every accepted word comes out after the fixed latency
  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Lat done_o)
    else $error("accepted word did not produce a result");

  // no result without an accepted word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cnt_q == ($clog2(Lat+1))'(Lat) && $past(start_i && !busy_o, Lat)))
    else $error("result without an accepted word");

  // pipeline never pushes back on pixels or config
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && cfg_ready_o)
    else $error("block refused a word");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !done_o)
    else $error("result right after reset");

endmodule

bind rgb_to_hsi_color_threshold hsi_chk #(.FRAC_BITS(FRAC_BITS)) u_hsi_chk (.*);

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import hsi_pkg::*;

  localparam int unsigned FracBits = 4;
  localparam int unsigned Latency  = FracBits + 12;

  typedef struct packed {
    logic        in_window;
    logic [12:0] hue;
    logic [11:0] sat;
    logic [11:0] inten;
  } hsi_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [7:0]          chan_first_i = '0;
  logic [7:0]          chan_second_i = '0;
  logic [7:0]          chan_third_i = '0;
  logic                done_o;
  logic                in_window_o;
  logic [12:0]         hue_sixteenths_o;
  logic [11:0]         sat_sixteenths_o;
  logic [11:0]         int_sixteenths_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  rgb_to_hsi_color_threshold #(.FRAC_BITS(FracBits)) dut (.*);

  always #1 clk_i = ~clk_i;

  // window registers as the testbench believes them
  logic [8:0] win_hue_lo, win_hue_hi;
  logic [7:0] win_sat_lo, win_sat_hi, win_int_lo, win_int_hi;

  hsi_word_t pending_hsi[$];
  int        n_errors = 0;

  // lower bound test on a truncated fixed-point value
  function automatic bit at_least(longint unsigned q, longint unsigned lo);
    return q >= (lo << FracBits);
  endfunction

  // upper bound test, exact flag resolves q == bound
  function automatic bit at_most(longint unsigned q, bit exact, longint unsigned hi);
    longint unsigned h;
    h = hi << FracBits;
    return (q < h) || (q == h && exact);
  endfunction

  function automatic hsi_word_t predict_hsi(logic [7:0] rc, logic [7:0] gc, logic [7:0] bc);
    longint unsigned r, g, b, sum, mn, third, hq, sq, iq, num, den, th;
    bit hx, sx, ix, tx, hue_ok, pass;
    hsi_word_t w;
    r = rc; g = gc; b = bc;
    sum = r + g + b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    third = 120 << FracBits;
    hq = 0; sq = 0; hx = 1; sx = 1;
    iq = (sum << FracBits) / 3;
    ix = ((sum << FracBits) % 3) == 0;
    if (sum != 0) begin
      num = (255 * (sum - 3 * mn)) << FracBits;
      sq = num / sum;
      sx = (num % sum) == 0;
    end
    // minimum ties go to red first, then green
    if (mn == r) begin
      den = g + b - 2 * r;
      if (den != 0) begin
        num = third * (g + 2 * b - 3 * r);
        hq = num / den; hx = (num % den) == 0;
      end
    end else if (mn == g) begin
      den = r + b - 2 * g;
      if (den != 0) begin
        num = third * (r - g + 2 * den);
        hq = num / den; hx = (num % den) == 0;
      end
    end else begin
      den = r + g - 2 * b;
      if (den != 0) begin
        // small blue-minimum offset, scaled by 250 to stay integer
        num = third * (g - b) * 250 + 9 * (1 << FracBits) * den;
        hq = num / (250 * den); hx = (num % (250 * den)) == 0;
      end
    end
    // gray forcing only for the window test
    th = hq; tx = hx;
    if (r == g || g == b) begin
      th = 0; tx = 1;
    end
    if (win_hue_lo <= win_hue_hi)
      hue_ok = at_least(th, win_hue_lo) && at_most(th, tx, win_hue_hi);
    else
      hue_ok = at_least(th, win_hue_lo) || at_most(th, tx, win_hue_hi);
    pass = hue_ok && at_least(sq, win_sat_lo) && at_most(sq, sx, win_sat_hi)
        && at_least(iq, win_int_lo) && at_most(iq, ix, win_int_hi);
    w.in_window = pass;
    w.hue = hq[12:0];
    w.sat = sq[11:0];
    w.inten = iq[11:0];
    return w;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    hsi_word_t want, got;
    if (rst_ni && done_o) begin
      got = '{in_window_o, hue_sixteenths_o, sat_sixteenths_o, int_sixteenths_o};
      if (pending_hsi.size() == 0) begin
        $display("%0t: unexpected word, actual %p", $time, got);
        n_errors++;
      end else begin
        want = pending_hsi.pop_front();
        if (got.in_window !== want.in_window) begin
          $display("%0t: in_window expected %0d actual %0d", $time, want.in_window,
                   got.in_window);
          n_errors++;
        end
        if (got.hue !== want.hue) begin
          $display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
          n_errors++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: sat expected %0d actual %0d", $time, want.sat, got.sat);
          n_errors++;
        end
        if (got.inten !== want.inten) begin
          $display("%0t: int expected %0d actual %0d", $time, want.inten, got.inten);
          n_errors++;
        end
      end
    end
  end

  // one pixel word, optional random gap before it
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit gaps = 1);
    int gap;
    gap = gaps ? (($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    chan_first_i <= r;
    chan_second_i <= g;
    chan_third_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_hsi.push_back(predict_hsi(r, g, b));
  endtask

  // drain all results, then idle for more than the pipeline depth
  task automatic drain();
    int guard;
    start_i <= 1'b0;
    guard = 0;
    while (pending_hsi.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_HUE_LOW:  win_hue_lo = val;
      REG_HUE_HIGH: win_hue_hi = val;
      REG_SAT_LOW:  win_sat_lo = val[7:0];
      REG_SAT_HIGH: win_sat_hi = val[7:0];
      REG_INT_LOW:  win_int_lo = val[7:0];
      REG_INT_HIGH: win_int_hi = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_windows(logic [8:0] hl, logic [8:0] hh, logic [7:0] sl,
                             logic [7:0] sh, logic [7:0] il, logic [7:0] ih);
    drain();
    write_reg(REG_HUE_LOW, hl);
    write_reg(REG_HUE_HIGH, hh);
    write_reg(REG_SAT_LOW, {1'b0, sl});
    write_reg(REG_SAT_HIGH, {1'b0, sh});
    write_reg(REG_INT_LOW, {1'b0, il});
    write_reg(REG_INT_HIGH, {1'b0, ih});
  endtask

  // extremes, ties, gray, each minimum channel
  task automatic test_directed();
    send_pixel(0, 0, 0, 0);
    send_pixel(255, 255, 255, 0);
    send_pixel(255, 0, 0, 0);
    send_pixel(0, 255, 0, 0);
    send_pixel(0, 0, 255, 0);
    send_pixel(255, 255, 0, 0);
    send_pixel(0, 255, 255, 0);
    send_pixel(255, 0, 255, 0);
    send_pixel(10, 10, 200, 0);
    send_pixel(200, 10, 10, 0);
    send_pixel(10, 200, 10, 0);
    send_pixel(128, 128, 128, 0);
    send_pixel(1, 0, 0, 0);
    send_pixel(0, 0, 1, 0);
    send_pixel(170, 85, 85, 0);
    send_pixel(85, 170, 42, 0);
    send_pixel(42, 85, 170, 0);
    send_pixel(255, 254, 253, 0);
  endtask

  task automatic test_random(int n);
    logic [7:0] r, g, b;
    repeat (n) begin
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      case ($urandom_range(0, 5))
        0: g = r;  // gray forcing cases
        1: b = g;
        2: begin g = r; b = r; end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  // fixed and random windows, wrapping ones among them
  task automatic test_windows();
    set_windows(9'd300, 9'd60, 8'd0, 8'd255, 8'd0, 8'd255);
    test_random(200);
    set_windows(9'd511, 9'd511, 8'd255, 8'd255, 8'd255, 8'd255);
    test_directed();
    test_random(100);
    set_windows(9'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    test_directed();
    test_random(100);
    repeat (6) begin
      set_windows(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      test_random(150);
    end
  endtask

  initial begin
    win_hue_lo = 0; win_hue_hi = 360;
    win_sat_lo = 0; win_sat_hi = 255;
    win_int_lo = 0; win_int_hi = 255;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300);
    test_windows();
    drain();
    if (n_errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
